FILE: rtl/lip_pkg.sv
// Shared types and constants for the linear interpolation lookup.
// Used by every module of the block but lip_ram; depends on nothing else.
`timescale 1ns / 1ps
package lip_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int MAG_W       = VALUE_WIDTH + 1;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int QUO_W       = 41;
  localparam int HALF_W      = (MAG_W + 1) / 2;
  localparam int PP_W        = 2 * HALF_W;
  localparam int RES_W       = QUO_W + 2;
  localparam int REM_W       = MAG_W + 1;
  localparam int QCNT_W      = $clog2(QUO_W + 1);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e                 opcode;
    logic [ADDR_W-1:0]       load_index;
    logic [VALUE_WIDTH-1:0]  load_x;
    logic [VALUE_WIDTH-1:0]  load_y;
    logic [VALUE_WIDTH-1:0]  query_value;
    logic                    last_query;
  } item_t;

endpackage

FILE: rtl/lip_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps
module lip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/lip_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on lip_pkg.
`timescale 1ns / 1ps
module lip_front
  import lip_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  avail_o,
  output item_t head_o,
  input  logic  pop_i
);

  item_t      fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = fifo_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/lip_back.sv
// Back end: table writes, forward segment search, multiply and divide.
// Depends on lip_pkg and lip_ram.
`timescale 1ns / 1ps
module lip_back
  import lip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [CNT_W-1:0]       point_count_i,
  input  logic                   avail_i,
  input  item_t                  head_i,
  output logic                   pop_o,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] interp_value_o,
  output logic [ADDR_W-1:0]      segment_o,
  output logic                   zero_width_o,
  output logic                   saturated_o
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_CLAMP = 12'b000000000010,
    ST_SRD   = 12'b000000000100,
    ST_SCMP  = 12'b000000001000,
    ST_RD0   = 12'b000000010000,
    ST_RD1   = 12'b000000100000,
    ST_LAT   = 12'b000001000000,
    ST_DIFF  = 12'b000010000000,
    ST_MUL   = 12'b000100000000,
    ST_DCHK  = 12'b001000000000,
    ST_DIV   = 12'b010000000000,
    ST_FIN   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [VALUE_WIDTH-1:0] q_q, x0_q, y0_q, x1_q, y1_q;
  logic                   last_q;
  logic [MAG_W-1:0]       ma_q, mb_q, md_q;
  logic                   neg_q, zw_q;
  logic [2:0]             step_q;
  logic [PP_W-1:0]        pp_q;
  logic [PROD_W-1:0]      prod_q;
  logic [REM_W-1:0]       rem_q;
  logic [QUO_W-1:0]       quo_q;
  logic [QCNT_W-1:0]      qcnt_q;

  logic [CNT_W-1:0]       cnt, cnt_m1;
  logic [ADDR_W-1:0]      raddr;
  logic [VALUE_WIDTH-1:0] xr, yr;
  logic                   ram_we;

  // Clamp the register to the usable range of entries.
  always_comb begin
    cnt = point_count_i;
    if (point_count_i < CNT_W'(2)) begin
      cnt = CNT_W'(2);
    end else if (point_count_i > CNT_W'(TABLE_DEPTH)) begin
      cnt = CNT_W'(TABLE_DEPTH);
    end
    cnt_m1 = cnt - CNT_W'(1);
  end

  assign ram_we = (state_q == ST_IDLE) && avail_i && (head_i.opcode == OP_LOAD);
  assign pop_o  = (state_q == ST_IDLE) && avail_i;

  always_comb begin
    raddr = ptr_q[ADDR_W-1:0];
    if (state_q == ST_RD0) begin
      raddr = ptr_q[ADDR_W-1:0] - ADDR_W'(1);
    end
  end

  lip_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_xram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.load_index),
    .wdata_i (head_i.load_x),
    .raddr_i (raddr),
    .rdata_o (xr)
  );

  lip_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_DEPTH)) u_yram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.load_index),
    .wdata_i (head_i.load_y),
    .raddr_i (raddr),
    .rdata_o (yr)
  );

  // Differences of the segment, sign-extended by one bit.
  logic signed [MAG_W-1:0] dq, dy, dx;
  assign dq = MAG_W'($signed(q_q))  - MAG_W'($signed(x0_q));
  assign dy = MAG_W'($signed(y1_q)) - MAG_W'($signed(y0_q));
  assign dx = MAG_W'($signed(x1_q)) - MAG_W'($signed(x0_q));

  // Partial product selection: the multiply forms four partial products.
  logic [HALF_W-1:0] pa, pb;
  always_comb begin
    pa = HALF_W'(ma_q[HALF_W-1:0]);
    pb = HALF_W'(mb_q[HALF_W-1:0]);
    case (step_q)
      3'd1: pb = HALF_W'(mb_q[MAG_W-1:HALF_W]);
      3'd2: pa = HALF_W'(ma_q[MAG_W-1:HALF_W]);
      3'd3: begin
        pa = HALF_W'(ma_q[MAG_W-1:HALF_W]);
        pb = HALF_W'(mb_q[MAG_W-1:HALF_W]);
      end
      default: ;
    endcase
  end

  logic [PROD_W-1:0] pp_sh;
  always_comb begin
    case (step_q)
      3'd2, 3'd3: pp_sh = PROD_W'(pp_q) << HALF_W;
      3'd4:       pp_sh = PROD_W'(pp_q) << (2 * HALF_W);
      default:    pp_sh = PROD_W'(pp_q);
    endcase
  end

  logic [REM_W-1:0] rem_sh;
  logic             rem_ge;
  assign rem_sh = {rem_q[REM_W-2:0], prod_q[QUO_W-1]};
  assign rem_ge = rem_sh >= REM_W'(md_q);

  logic [QUO_W-1:0]        mag;
  logic signed [RES_W-1:0] sum;
  logic                    sat;
  logic [VALUE_WIDTH-1:0]  res;
  always_comb begin
    mag = (quo_q > (QUO_W'(1) << (QUO_W - 1))) ? (QUO_W'(1) << (QUO_W - 1)) : quo_q;
    if (neg_q) begin
      sum = RES_W'($signed(y0_q)) - $signed(RES_W'(mag));
    end else begin
      sum = RES_W'($signed(y0_q)) + $signed(RES_W'(mag));
    end
    if (zw_q) begin
      sum = RES_W'($signed(y0_q));
    end
    sat = 1'b0;
    res = sum[VALUE_WIDTH-1:0];
    if (sum > $signed(RES_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}}))) begin
      sat = 1'b1;
      res = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (sum < -$signed(RES_W'({1'b1, {(VALUE_WIDTH-1){1'b0}}}))) begin
      sat = 1'b1;
      res = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (avail_i && head_i.opcode == OP_QUERY) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (ptr_q > cnt_m1) begin
          ptr_d = cnt_m1;
        end else if (ptr_q == CNT_W'(0)) begin
          ptr_d = CNT_W'(1);
        end
        state_d = ST_SRD;
      end
      ST_SRD:  state_d = ST_SCMP;
      ST_SCMP: begin
        if (ptr_q < cnt_m1 && $signed(q_q) >= $signed(xr)) begin
          ptr_d   = ptr_q + CNT_W'(1);
          state_d = ST_SRD;
        end else begin
          state_d = ST_RD0;
        end
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_LAT;
      ST_LAT:  state_d = ST_DIFF;
      ST_DIFF: state_d = (dx == '0) ? ST_FIN : ST_MUL;
      ST_MUL:  state_d = (step_q == 3'd4) ? ST_DCHK : ST_MUL;
      ST_DCHK: begin
        state_d = (PROD_W'(prod_q[PROD_W-1:QUO_W]) >= PROD_W'(md_q)) ? ST_FIN : ST_DIV;
      end
      ST_DIV:  state_d = (qcnt_q == QCNT_W'(QUO_W - 1)) ? ST_FIN : ST_DIV;
      ST_FIN: begin
        if (last_q) begin
          ptr_d = CNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        q_q    <= head_i.query_value;
        last_q <= head_i.last_query;
      end
      ST_RD1: begin
        x0_q <= xr;
        y0_q <= yr;
      end
      ST_LAT: begin
        x1_q <= xr;
        y1_q <= yr;
      end
      ST_DIFF: begin
        zw_q   <= (dx == '0);
        quo_q  <= '0;
        ma_q   <= dq[MAG_W-1] ? MAG_W'(-dq) : MAG_W'(dq);
        mb_q   <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        md_q   <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        neg_q  <= dq[MAG_W-1] ^ dy[MAG_W-1] ^ dx[MAG_W-1];
        step_q <= 3'd0;
        prod_q <= '0;
      end
      ST_MUL: begin
        // The product of one step is registered and added in the next.
        pp_q   <= pa * pb;
        if (step_q != 3'd0) begin
          prod_q <= prod_q + pp_sh;
        end
        step_q <= step_q + 3'd1;
      end
      ST_DCHK: begin
        // A quotient at or above the cap width saturates the magnitude.
        quo_q  <= QUO_W'(1) << (QUO_W - 1);
        rem_q  <= REM_W'(prod_q[PROD_W-1:QUO_W]);
        qcnt_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= rem_ge ? rem_sh - REM_W'(md_q) : rem_sh;
        quo_q  <= {quo_q[QUO_W-2:0], rem_ge};
        prod_q <= {prod_q[PROD_W-2:0], 1'b0};
        qcnt_q <= qcnt_q + QCNT_W'(1);
      end
      ST_FIN: begin
        interp_value_o <= res;
        segment_o      <= ptr_q[ADDR_W-1:0];
        zero_width_o   <= zw_q;
        saturated_o    <= sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= CNT_W'(1);
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      valid_o <= (state_q == ST_FIN);
    end
  end

endmodule

FILE: rtl/linear_interpolation_lookup.sv
// Top level of the piecewise linear interpolation lookup.
// Depends on lip_pkg, lip_front and lip_back.
//
//  channel   direction  handshake                    payload
//  request   in         start, busy                  opcode_i .. last_query_i
//  result    out        valid_o (one cycle, no hold) interp_value_o .. saturated_o
//  config    in         point_count_we_i             point_count_i
//
// A load request is written into the table while the back end is idle. A query
// clamps the search pointer, then reads and compares breakpoints as the pointer
// steps forward, reads both ends of the segment, forms the differences, then runs
// the multiply and the serial 41-bit divide; the back end takes no new request
// until its result is out. A zero-width segment skips the multiply and divide and
// a capped quotient skips the divide.
// Reset puts the search pointer at 1 and point_count at 2; the table is
// undefined until loaded. busy is high while the two-entry request queue is full.
// The receiver cannot stall: each result stands for exactly one cycle.
`timescale 1ns / 1ps
module linear_interpolation_lookup
  import lip_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   opcode_i,
  input  logic [ADDR_W-1:0]      load_index_i,
  input  logic [VALUE_WIDTH-1:0] load_x_i,
  input  logic [VALUE_WIDTH-1:0] load_y_i,
  input  logic [VALUE_WIDTH-1:0] query_value_i,
  input  logic                   last_query_i,
  input  logic                   point_count_we_i,
  input  logic [CNT_W-1:0]       point_count_i,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] interp_value_o,
  output logic [ADDR_W-1:0]      segment_o,
  output logic                   zero_width_o,
  output logic                   saturated_o
);

  logic [CNT_W-1:0] point_count_q;
  item_t            item, head;
  logic             full, avail, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CNT_W'(2);
    end else if (point_count_we_i) begin
      point_count_q <= point_count_i;
    end
  end

  always_comb begin
    item.opcode      = opcode_e'(opcode_i);
    item.load_index  = load_index_i;
    item.load_x      = load_x_i;
    item.load_y      = load_y_i;
    item.query_value = query_value_i;
    item.last_query  = last_query_i;
  end

  assign busy = full;

  lip_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start && !full),
    .item_i  (item),
    .full_o  (full),
    .avail_o (avail),
    .head_o  (head),
    .pop_i   (pop)
  );

  lip_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .point_count_i  (point_count_q),
    .avail_i        (avail),
    .head_i         (head),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .interp_value_o (interp_value_o),
    .segment_o      (segment_o),
    .zero_width_o   (zero_width_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: dv/tb_linear_interpolation_lookup.sv
// Self-checking testbench for linear_interpolation_lookup: loads breakpoint tables,
// sends query batches, mostly ascending, and checks every result against a local predictor.
// Depends on lip_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_linear_interpolation_lookup;
  import lip_pkg::*;

  localparam int  CYCLE_LIMIT = 3000000;
  localparam int  DRAIN_WAIT  = 700;
  localparam longint MAG_LIMIT = 64'sd1 << 40;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [ADDR_W-1:0]      seg;
    logic                   zw;
    logic                   sat;
  } interp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic opcode_i = 1'b0;
  logic [ADDR_W-1:0] load_index_i = '0;
  logic [VALUE_WIDTH-1:0] load_x_i = '0, load_y_i = '0, query_value_i = '0;
  logic last_query_i = 1'b0;
  logic point_count_we_i = 1'b0;
  logic [CNT_W-1:0] point_count_i = '0;
  logic valid_o;
  logic [VALUE_WIDTH-1:0] interp_value_o;
  logic [ADDR_W-1:0] segment_o;
  logic zero_width_o, saturated_o;

  linear_interpolation_lookup dut (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .load_index_i, .load_x_i, .load_y_i,
    .query_value_i, .last_query_i, .point_count_we_i, .point_count_i, .valid_o,
    .interp_value_o, .segment_o, .zero_width_o, .saturated_o
  );

  always #5 clk_i = ~clk_i;

  item_t   request_q[$];
  interp_t expected_q[$];
  longint  x_tab[TABLE_DEPTH];
  longint  y_tab[TABLE_DEPTH];
  int      seg_ptr = 1;
  int      pts_cfg = 2;
  item_t   cur;
  bit      took = 0;
  int      gap_left = 0;
  bit      burst_mode = 0;
  int      errors = 0;
  int      cycles = 0;
  int      rand_items = 0;
  int      big_phases = 0;

  function automatic interp_t interpolate(item_t it);
    interp_t res;
    int     cnt;
    longint q, x0, x1, y0, y1, r, mag;
    logic [VALUE_WIDTH:0] mq, my, mx;
    logic [2*VALUE_WIDTH+1:0] prod, quo;
    bit neg;
    cnt = (pts_cfg < 2) ? 2 : (pts_cfg > TABLE_DEPTH) ? TABLE_DEPTH : pts_cfg;
    q = longint'($signed(it.query_value));
    if (seg_ptr > cnt - 1) seg_ptr = cnt - 1;
    if (seg_ptr < 1) seg_ptr = 1;
    while (seg_ptr < cnt - 1 && q >= x_tab[seg_ptr]) seg_ptr++;
    x0 = x_tab[seg_ptr-1];
    x1 = x_tab[seg_ptr];
    y0 = y_tab[seg_ptr-1];
    y1 = y_tab[seg_ptr];
    res.zw = (x1 == x0);
    if (res.zw) begin
      r = y0;
    end else begin
      // Magnitudes fit in 33 bits; the sign is recombined after the divide.
      mq = (VALUE_WIDTH+1)'((q - x0 < 0) ? x0 - q : q - x0);
      my = (VALUE_WIDTH+1)'((y1 - y0 < 0) ? y0 - y1 : y1 - y0);
      mx = (VALUE_WIDTH+1)'((x1 - x0 < 0) ? x0 - x1 : x1 - x0);
      neg = ((q - x0 < 0) != (y1 - y0 < 0)) != (x1 - x0 < 0);
      prod = mq * my;
      quo = prod / mx;
      mag = (quo > MAG_LIMIT) ? MAG_LIMIT : longint'(quo);
      r = neg ? y0 - mag : y0 + mag;
    end
    res.sat = 1'b0;
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = r[VALUE_WIDTH-1:0];
    res.seg = seg_ptr[ADDR_W-1:0];
    if (it.last_query) seg_ptr = 1;
    return res;
  endfunction

  // Request driver: at most one start assignment per falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      took = 0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur = request_q.pop_front();
        opcode_i      <= cur.opcode;
        load_index_i  <= cur.load_index;
        load_x_i      <= cur.load_x;
        load_y_i      <= cur.load_y;
        query_value_i <= cur.query_value;
        last_query_i  <= cur.last_query;
        start         <= 1'b1;
        if ($urandom_range(0, 39) == 0) burst_mode = ~burst_mode;
        gap_left = burst_mode ? 0 : $urandom_range(0, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: request acceptance, predictor update and result check.
  always @(posedge clk_i) begin
    interp_t got, want;
    if (rst_ni) begin
      if (point_count_we_i) pts_cfg = int'(point_count_i);
      if (start && !busy) begin
        took = 1;
        if (cur.opcode == OP_LOAD) begin
          x_tab[cur.load_index] = longint'($signed(cur.load_x));
          y_tab[cur.load_index] = longint'($signed(cur.load_y));
        end else begin
          expected_q.push_back(interpolate(cur));
        end
      end
      if (valid_o) begin
        got.value = interp_value_o;
        got.seg = segment_o;
        got.zw = zero_width_o;
        got.sat = saturated_o;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: value %h seg %0d", got.value, got.seg);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp value %h seg %0d zw %b sat %b, got %h %0d %b %b",
                       want.value, want.seg, want.zw, want.sat,
                       got.value, got.seg, got.zw, got.sat);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic item_t load_req(int idx, longint x, longint y);
    item_t it;
    it = '0;
    it.opcode = OP_LOAD;
    it.load_index = idx[ADDR_W-1:0];
    it.load_x = x[VALUE_WIDTH-1:0];
    it.load_y = y[VALUE_WIDTH-1:0];
    it.query_value = $urandom();
    it.last_query = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t query_req(longint q, bit last);
    item_t it;
    it.opcode = OP_QUERY;
    it.load_index = ADDR_W'($urandom());
    it.load_x = $urandom();
    it.load_y = $urandom();
    it.query_value = q[VALUE_WIDTH-1:0];
    it.last_query = last;
    return it;
  endfunction

  function automatic longint clip32(longint v);
    return (v > 64'sd2147483647) ? 64'sd2147483647 :
           (v < -64'sd2147483648) ? -64'sd2147483648 : v;
  endfunction

  task automatic wait_idle();
    while (request_q.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    // Trailing loads produce no result, so give them time to retire.
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_count(int value);
    @(negedge clk_i);
    point_count_we_i <= 1'b1;
    point_count_i <= value[CNT_W-1:0];
    @(negedge clk_i);
    point_count_we_i <= 1'b0;
  endtask

  // One table setting: write the count, load the active entries, then query batches.
  task automatic run_phase(int cfg, int batches);
    int n, m, steep;
    longint x, lo, hi, qs[$];
    wait_idle();
    write_count(cfg);
    n = (cfg < 2) ? 2 : (cfg > TABLE_DEPTH) ? TABLE_DEPTH : cfg;
    steep = $urandom_range(0, 3);
    x = longint'($signed($urandom())) >>> $urandom_range(0, 8);
    lo = x;
    for (int i = 0; i < n; i++) begin
      request_q.push_back(load_req(i, x, longint'($signed($urandom())) >>> steep));
      rand_items++;
      hi = x;
      if ($urandom_range(0, 15) == 0) x = clip32(x - $urandom_range(0, 1000));
      else if ($urandom_range(0, 7) == 0) x = x;
      else x = clip32(x + $urandom_range(1, 1 << $urandom_range(0, 24)));
    end
    for (int b = 0; b < batches; b++) begin
      m = $urandom_range(1, 8);
      qs.delete();
      for (int i = 0; i < m; i++) begin
        if ($urandom_range(0, 9) == 0) qs.push_back(longint'($signed($urandom())));
        else qs.push_back(lo - 4096 + longint'($urandom_range(0, 32'hffff_ffff)) %
                          (hi - lo + 8193));
      end
      if ($urandom_range(0, 7) != 0) qs.sort();
      foreach (qs[i]) begin
        if ($urandom_range(0, 9) == 0) begin
          request_q.push_back(load_req($urandom_range(n, 255), $urandom(), $urandom()));
          rand_items++;
        end
        // A batch left open carries its pointer into the next batch or the next setting.
        request_q.push_back(query_req(clip32(qs[i]),
                            (i == m - 1) && ($urandom_range(0, 5) != 0)));
        rand_items++;
      end
    end
  endtask

  initial begin
    int cfg;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full-range segment, then zero-width and saturating segments.
    request_q.push_back(load_req(0, -64'sd2147483648, -64'sd2147483648));
    request_q.push_back(load_req(1, 64'sd2147483647, 64'sd2147483647));
    request_q.push_back(query_req(-64'sd2147483648, 1'b0));
    request_q.push_back(query_req(0, 1'b0));
    request_q.push_back(query_req(64'sd2147483647, 1'b1));
    request_q.push_back(load_req(1, -64'sd2147483648, 5));
    request_q.push_back(query_req(123, 1'b1));
    request_q.push_back(load_req(0, 0, 0));
    request_q.push_back(load_req(1, 1, 64'sd2147483647));
    request_q.push_back(query_req(64'sd2147483647, 1'b1));
    request_q.push_back(query_req(-64'sd2147483648, 1'b1));
    request_q.push_back(load_req(1, 1, -64'sd2147483648));
    request_q.push_back(query_req(64'sd2147483647, 1'b1));
    request_q.push_back(query_req(-64'sd2147483648, 1'b0));

    run_phase(2, 4);
    run_phase(TABLE_DEPTH, 6);
    run_phase(0, 3);
    run_phase(511, 4);
    run_phase(1, 3);
    run_phase(3, 4);
    while (rand_items < 700) begin
      cfg = $urandom_range(2, 12);
      if ($urandom_range(0, 19) == 0) cfg = $urandom_range(0, 1);
      run_phase(cfg, $urandom_range(2, 8));
    end

    while (request_q.size() > 0 || start) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
